@@ hw/rtl/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared constants for the Blum-Goldwasser decrypt core: widths, register
// indexes, reset values and operation codes.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PRIME_W  = 16;
  localparam int unsigned COEF_W   = 17;
  localparam int unsigned EXP_W    = 16;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PRIME_BITS_DEF = 16;
  localparam int unsigned KEY_BITS_DEF   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_P   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_Q   = 3'd5;

  localparam logic [PRIME_W-1:0] PRIME_P_RST = 16'd499;
  localparam logic [PRIME_W-1:0] PRIME_Q_RST = 16'd547;
  localparam logic [COEF_W-1:0]  COEF_A_RST  = 17'h1FFC7; // -57
  localparam logic [COEF_W-1:0]  COEF_B_RST  = 17'd52;
  localparam logic [EXP_W-1:0]   EXP_P_RST   = 16'd463;
  localparam logic [EXP_W-1:0]   EXP_Q_RST   = 16'd337;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_CIPHER = 1'b1;

endpackage

@@ hw/rtl/bgd_modmul.sv @@
// ----------------------------------------------------------------------------
// bgd_modmul
// Bit-serial interleaved modular multiplier: res = (a * b) mod m, one bit of a
// per cycle, MSB first. Requires b < m. A zero modulus returns zero.
// ----------------------------------------------------------------------------
module bgd_modmul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bgd_pkg::WORD_W-1:0]  a_i,
  input  logic [bgd_pkg::WORD_W-1:0]  b_i,
  input  logic [bgd_pkg::WORD_W-1:0]  m_i,
  output logic                        done_o,
  output logic [bgd_pkg::WORD_W-1:0]  res_o
);

  localparam int unsigned W = bgd_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     a_q, b_q, m_q, r_q, r_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [W:0]       dbl, dbl_red, acc, acc_red;

  // r = 2r mod m, then r = (r + bit*b) mod m; both stay below 2m
  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    acc     = {1'b0, dbl_red[W-1:0]} + (a_q[W-1] ? {1'b0, b_q} : '0);
    acc_red = (acc >= {1'b0, m_q}) ? acc - {1'b0, m_q} : acc;
    r_d     = acc_red[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (busy_q) begin
      a_q <= {a_q[W-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = (m_q == '0) ? '0 : r_q;

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (m_q == '0 || r_q < m_q)) else $error("modmul result out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("modmul started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("modmul done while busy");

endmodule

@@ hw/rtl/blum_goldwasser_decrypt_core.sv @@
// Cipher transaction: two modular multiplies mod n.
// Load transaction: up to 73 modular multiplies (two 16-bit square-and-multiply
// exponentiations plus CRT recombination and a final squaring).
// One transaction at a time; the bit-serial multiplier (one bit per cycle) sets the rate.
// The plain nibble waits in a pending register and moves to the output once that register is free.
// Asynchronous active-low reset restores default registers and clears key state.
// ----------------------------------------------------------------------------
// blum_goldwasser_decrypt_core
// Blum-Goldwasser decryption: recovers the seed from the final generator
// state and streams plaintext nibbles from the squaring generator.
// ----------------------------------------------------------------------------
module blum_goldwasser_decrypt_core #(
  parameter int unsigned PRIME_BITS = bgd_pkg::PRIME_BITS_DEF,
  parameter int unsigned KEY_BITS   = bgd_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgd_pkg::COEF_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [bgd_pkg::WORD_W-1:0]     load_value_i,
  input  logic [bgd_pkg::NIBBLE_W-1:0]   cipher_nibble_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bgd_pkg::NIBBLE_W-1:0]   plain_nibble_o
);

  localparam int unsigned W  = bgd_pkg::WORD_W;
  localparam int unsigned PW = bgd_pkg::PRIME_W;
  localparam int unsigned CW = bgd_pkg::COEF_W;
  localparam int unsigned NW = bgd_pkg::NIBBLE_W;
  localparam int unsigned MASK_BITS = (PRIME_BITS < PW) ? PRIME_BITS : PW;
  localparam logic [PW-1:0] PMask = {PW{1'b1}} >> (PW - MASK_BITS);
  localparam logic [NW-1:0] KMask =
    (KEY_BITS >= NW) ? {NW{1'b1}} : NW'((1 << KEY_BITS) - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CRED  = 4'd1;
  localparam logic [3:0] ST_CSQ   = 4'd2;
  localparam logic [3:0] ST_LBASE = 4'd3;
  localparam logic [3:0] ST_LMUL  = 4'd4;
  localparam logic [3:0] ST_LSQ   = 4'd5;
  localparam logic [3:0] ST_CA    = 4'd6;
  localparam logic [3:0] ST_CAP   = 4'd7;
  localparam logic [3:0] ST_CAV   = 4'd8;
  localparam logic [3:0] ST_CB    = 4'd9;
  localparam logic [3:0] ST_CBQ   = 4'd10;
  localparam logic [3:0] ST_CBU   = 4'd11;
  localparam logic [3:0] ST_SUM   = 4'd12;
  localparam logic [3:0] ST_FSQ   = 4'd13;

  // configuration
  logic [PW-1:0] prime_p_q, prime_q_q;
  logic [CW-1:0] coef_a_q, coef_b_q;
  logic [bgd_pkg::EXP_W-1:0] exp_p_q, exp_q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_p_q <= bgd_pkg::PRIME_P_RST;
      prime_q_q <= bgd_pkg::PRIME_Q_RST;
      coef_a_q  <= bgd_pkg::COEF_A_RST;
      coef_b_q  <= bgd_pkg::COEF_B_RST;
      exp_p_q   <= bgd_pkg::EXP_P_RST;
      exp_q_q   <= bgd_pkg::EXP_Q_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bgd_pkg::REG_PRIME_P: prime_p_q <= cfg_wdata_i[PW-1:0];
        bgd_pkg::REG_PRIME_Q: prime_q_q <= cfg_wdata_i[PW-1:0];
        bgd_pkg::REG_COEF_A:  coef_a_q  <= cfg_wdata_i;
        bgd_pkg::REG_COEF_B:  coef_b_q  <= cfg_wdata_i;
        bgd_pkg::REG_EXP_P:   exp_p_q   <= cfg_wdata_i[bgd_pkg::EXP_W-1:0];
        bgd_pkg::REG_EXP_Q:   exp_q_q   <= cfg_wdata_i[bgd_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PW-1:0] p_m, q_m;
  logic [W-1:0]  n_comb;
  assign p_m    = prime_p_q & PMask;
  assign q_m    = prime_q_q & PMask;
  assign n_comb = W'(p_m) * W'(q_m);

  // sequencer state
  logic [3:0]    st_q, st_d;
  logic          go_q, sel_q;
  logic [3:0]    i_q;
  logic [W-1:0]  x_q, t_q, s_q, ks_q, n_q;
  logic [PW-1:0] bb_q, acc_q, u_q, v_q;
  logic          out_valid_q, pend_valid_q;
  logic [NW-1:0] out_plain_q, pend_plain_q;

  logic          accept, out_load, e_bit, mm_start, mm_done, skip_mul;
  logic [W-1:0]  mm_a, mm_b, mm_m, mm_res, mm_one, cur_p, fix_a, fix_b;
  logic [CW-1:0] abs_a, abs_b;
  logic [W:0]    sum_w, sum_red;

  assign in_stall_o = (st_q != ST_IDLE) || pend_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = pend_valid_q && (!out_valid_q || !out_stall_i);

  assign cur_p    = sel_q ? W'(q_m) : W'(p_m);
  assign e_bit    = sel_q ? exp_q_q[i_q] : exp_p_q[i_q];
  assign skip_mul = (st_q == ST_LMUL) && !e_bit;
  assign abs_a    = coef_a_q[CW-1] ? CW'(-coef_a_q) : coef_a_q;
  assign abs_b    = coef_b_q[CW-1] ? CW'(-coef_b_q) : coef_b_q;
  assign mm_one   = {{(W-1){1'b0}}, (mm_m != W'(1))};

  // negative coefficients map to n - (|c| mod n)
  assign fix_a = (coef_a_q[CW-1] && mm_res != '0) ? n_q - mm_res : mm_res;
  assign fix_b = (coef_b_q[CW-1] && mm_res != '0) ? n_q - mm_res : mm_res;

  assign sum_w   = {1'b0, s_q} + {1'b0, t_q};
  assign sum_red = (sum_w >= {1'b0, n_q}) ? sum_w - {1'b0, n_q} : sum_w;

  always_comb begin
    mm_a = '0;
    mm_b = '0;
    mm_m = n_q;
    case (st_q)
      ST_CRED:  begin mm_a = ks_q;       mm_b = mm_one; end
      ST_CSQ:   begin mm_a = ks_q;       mm_b = t_q;    end
      ST_LBASE: begin mm_m = cur_p; mm_a = x_q; mm_b = mm_one; end
      ST_LMUL:  begin mm_m = cur_p; mm_a = W'(acc_q); mm_b = W'(bb_q); end
      ST_LSQ:   begin mm_m = cur_p; mm_a = W'(bb_q);  mm_b = W'(bb_q); end
      ST_CA:    begin mm_a = W'(abs_a);  mm_b = mm_one; end
      ST_CAP:   begin mm_a = W'(p_m);    mm_b = t_q;    end
      ST_CAV:   begin mm_a = W'(v_q);    mm_b = t_q;    end
      ST_CB:    begin mm_a = W'(abs_b);  mm_b = mm_one; end
      ST_CBQ:   begin mm_a = W'(q_m);    mm_b = t_q;    end
      ST_CBU:   begin mm_a = W'(u_q);    mm_b = t_q;    end
      ST_FSQ:   begin mm_a = t_q;        mm_b = t_q;    end
      default: ;
    endcase
  end

  assign mm_start = !go_q && (st_q != ST_IDLE) && (st_q != ST_SUM) && !skip_mul;

  bgd_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (mm_m),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (accept) st_d = (op_i == bgd_pkg::OP_CIPHER) ? ST_CRED : ST_LBASE;
      ST_CRED:  if (mm_done) st_d = ST_CSQ;
      ST_CSQ:   if (mm_done) st_d = ST_IDLE;
      ST_LBASE: if (mm_done) st_d = ST_LMUL;
      ST_LMUL:  if (skip_mul || mm_done) st_d = ST_LSQ;
      ST_LSQ: begin
        if (mm_done) begin
          if (i_q == 4'd15) st_d = sel_q ? ST_CA : ST_LBASE;
          else              st_d = ST_LMUL;
        end
      end
      ST_CA:    if (mm_done) st_d = ST_CAP;
      ST_CAP:   if (mm_done) st_d = ST_CAV;
      ST_CAV:   if (mm_done) st_d = ST_CB;
      ST_CB:    if (mm_done) st_d = ST_CBQ;
      ST_CBQ:   if (mm_done) st_d = ST_CBU;
      ST_CBU:   if (mm_done) st_d = ST_SUM;
      ST_SUM:   st_d = ST_FSQ;
      ST_FSQ:   if (mm_done) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      go_q         <= 1'b0;
      sel_q        <= 1'b0;
      i_q          <= '0;
      ks_q         <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (mm_start)     go_q <= 1'b1;
      else if (mm_done) go_q <= 1'b0;

      if (accept) begin
        sel_q <= 1'b0;
        i_q   <= '0;
      end
      if (mm_done && st_q == ST_LBASE) i_q <= '0;
      if (mm_done && st_q == ST_LSQ) begin
        i_q <= i_q + 1'b1;
        if (i_q == 4'd15) sel_q <= 1'b1;
      end
      if (mm_done && (st_q == ST_CSQ || st_q == ST_FSQ)) ks_q <= mm_res;

      // pending nibble moves on once the output register is free
      if (accept && op_i == bgd_pkg::OP_CIPHER) begin
        pend_valid_q <= 1'b1;
      end else if (out_load) begin
        pend_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= load_value_i;
      n_q <= n_comb;
      if (op_i == bgd_pkg::OP_CIPHER) pend_plain_q <= cipher_nibble_i ^ (ks_q[NW-1:0] & KMask);
    end
    if (out_load) out_plain_q <= pend_plain_q;
    if (st_q == ST_SUM) t_q <= sum_red[W-1:0];
    if (mm_done) begin
      case (st_q)
        ST_CRED:  t_q <= mm_res;
        ST_LBASE: begin
          bb_q  <= mm_res[PW-1:0];
          acc_q <= mm_one[PW-1:0];
        end
        ST_LMUL:  acc_q <= mm_res[PW-1:0];
        ST_LSQ: begin
          bb_q <= mm_res[PW-1:0];
          if (i_q == 4'd15) begin
            if (sel_q) v_q <= acc_q;
            else       u_q <= acc_q;
          end
        end
        ST_CA:    t_q <= fix_a;
        ST_CAP:   t_q <= mm_res;
        ST_CAV:   s_q <= mm_res;
        ST_CB:    t_q <= fix_b;
        ST_CBQ:   t_q <= mm_res;
        ST_CBU:   t_q <= mm_res;
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plain_nibble_o = out_plain_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !accept) else $error("transaction accepted while busy");
  a_cipher_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == bgd_pkg::OP_CIPHER) |=> pend_valid_q) else $error("missing result");
  a_load_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == bgd_pkg::OP_LOAD && !out_valid_q) |=> !out_valid_q)
    else $error("load produced a result");
  a_go_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> (st_q != ST_IDLE)) else $error("multiplier pending while idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_plain_q)))
    else $error("stalled result changed");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Blum-Goldwasser decrypt core check: a directed table, then random load/cipher
// transactions, every plain nibble compared against a typed value or a local
// model of the key generator. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned PRIME_BITS = 16;
  localparam int unsigned KEY_BITS   = 4;
  localparam int unsigned RANDOM_ITEMS = 1050;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_idx_i = bgd_pkg::REG_PRIME_P;
  logic [bgd_pkg::COEF_W-1:0]    cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          op_i = bgd_pkg::OP_LOAD;
  logic [bgd_pkg::WORD_W-1:0]    load_value_i = '0;
  logic [bgd_pkg::NIBBLE_W-1:0]  cipher_nibble_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [bgd_pkg::NIBBLE_W-1:0]  plain_nibble_o;

  blum_goldwasser_decrypt_core #(
    .PRIME_BITS(PRIME_BITS),
    .KEY_BITS  (KEY_BITS)
  ) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model copy of the registers and key state
  logic [15:0]        m_prime_p, m_prime_q, m_exp_p, m_exp_q;
  logic signed [16:0] m_coef_a, m_coef_b;
  logic [31:0]        m_key;

  logic [bgd_pkg::NIBBLE_W-1:0] nibble_queue[$];
  int  errors = 0;
  bit  stall_mode = 0;

  typedef struct {
    logic              op;
    logic [31:0]       value;
    logic [3:0]        nib;
    bit                has_exp;
    logic [3:0]        exp_nib;
  } stim_row_t;

  function automatic logic [63:0] pow_mod(logic [63:0] base, logic [15:0] e,
                                          logic [63:0] m);
    logic [63:0] acc, b;
    if (m == 0) return 0;
    acc = 1 % m;
    b = base % m;
    for (int i = 0; i < 16; i++) begin
      if (e[i]) acc = (acc * b) % m;
      b = (b * b) % m;
    end
    return acc;
  endfunction

  function automatic logic [63:0] sq_mod(logic [63:0] x, logic [63:0] m);
    if (m == 0) return 0;
    x = x % m;
    return (x * x) % m;
  endfunction

  // advances the key generator for one transaction; returns 1 with a nibble
  function automatic bit decrypt_step(logic op, logic [31:0] value, logic [3:0] nib,
                                      output logic [3:0] plain);
    logic [63:0] p, q, n, u, v, x0;
    longint sum, r;
    p = m_prime_p & ((64'd1 << PRIME_BITS) - 1);
    q = m_prime_q & ((64'd1 << PRIME_BITS) - 1);
    n = p * q;
    plain = '0;
    if (op == bgd_pkg::OP_LOAD) begin
      u = pow_mod(64'(value), m_exp_p, p);
      v = pow_mod(64'(value), m_exp_q, q);
      sum = longint'(v) * longint'(m_coef_a) * longint'(p)
          + longint'(u) * longint'(m_coef_b) * longint'(q);
      x0 = 0;
      if (n != 0) begin
        r = sum % longint'(n);
        if (r < 0) r += longint'(n);
        x0 = r;
      end
      m_key = 32'(sq_mod(x0, n));
      return 0;
    end
    plain = 4'(nib ^ (m_key & ((64'd1 << KEY_BITS) - 1)));
    m_key = 32'(sq_mod(64'(m_key), n));
    return 1;
  endfunction

  task automatic write_reg(logic [bgd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bgd_pkg::COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bgd_pkg::REG_PRIME_P: m_prime_p = data[15:0];
      bgd_pkg::REG_PRIME_Q: m_prime_q = data[15:0];
      bgd_pkg::REG_COEF_A:  m_coef_a = data;
      bgd_pkg::REG_COEF_B:  m_coef_b = data;
      bgd_pkg::REG_EXP_P:   m_exp_p = data[15:0];
      bgd_pkg::REG_EXP_Q:   m_exp_q = data[15:0];
      default: ;
    endcase
  endtask

  // loads give no result, so allow the longest load latency after the last nibble
  task automatic wait_idle();
    while (nibble_queue.size() != 0) @(negedge clk_i);
    repeat (3000) @(negedge clk_i);
  endtask

  // drives one transaction at the falling edge, waits for its acceptance;
  // a typed expectation replaces the model's nibble
  task automatic send(logic op, logic [31:0] value, logic [3:0] nib,
                      bit has_exp, logic [3:0] exp_nib);
    logic [3:0] plain;
    in_valid_i <= 1'b1;
    op_i <= op;
    load_value_i <= value;
    cipher_nibble_i <= nib;
    do @(posedge clk_i); while (in_stall_o);
    if (decrypt_step(op, value, nib, plain))
      nibble_queue.push_back(has_exp ? exp_nib : plain);
    @(negedge clk_i);
  endtask

  task automatic gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 40)) @(negedge clk_i);
  endtask

  // receiver stall pattern: alternates between quiet and choppy stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
    out_stall_i <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (nibble_queue.size() == 0) begin
        $display("%0t: unexpected plain_nibble %h", $time, plain_nibble_o);
        errors++;
      end else begin
        if (plain_nibble_o !== nibble_queue[0]) begin
          $display("%0t: plain_nibble expected %h actual %h", $time,
                   nibble_queue[0], plain_nibble_o);
          errors++;
        end
        void'(nibble_queue.pop_front());
      end
    end
  end

  // random session: cipher nibbles mixed with occasional loads, sent in bursts
  task automatic random_phase(int count);
    int burst;
    int sent;
    sent = 0;
    burst = 0;
    while (sent < count) begin
      if (burst == 0) begin
        gap();
        burst = $urandom_range(1, 30);
      end
      if ($urandom_range(0, 24) == 0)
        send(bgd_pkg::OP_LOAD, $urandom, '0, 1'b0, '0);
      else
        send(bgd_pkg::OP_CIPHER, $urandom, 4'($urandom_range(0, 15)), 1'b0, '0);
      burst--;
      sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  stim_row_t directed [14];

  initial begin
    m_prime_p = bgd_pkg::PRIME_P_RST; m_prime_q = bgd_pkg::PRIME_Q_RST;
    m_coef_a = bgd_pkg::COEF_A_RST;   m_coef_b = bgd_pkg::COEF_B_RST;
    m_exp_p = bgd_pkg::EXP_P_RST;     m_exp_q = bgd_pkg::EXP_Q_RST;
    m_key = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // key is zero after reset and after loading zero: nibbles pass through
    directed = '{
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'hF, 1, 4'hF},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'h0, 1, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'hFFFFFFFF, 4'hA, 1, 4'hA},
      '{bgd_pkg::OP_LOAD, 32'hFFFFFFFF, 4'h0, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'hF, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'h5, 0, 4'h0},
      '{bgd_pkg::OP_LOAD, 32'h0, 4'hF, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'h3, 1, 4'h3},
      '{bgd_pkg::OP_LOAD, 32'd12345, 4'h0, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'hC, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'h9, 0, 4'h0},
      '{bgd_pkg::OP_LOAD, 32'h80000000, 4'h0, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'h1, 0, 4'h0},
      '{bgd_pkg::OP_CIPHER, 32'h0, 4'hE, 0, 4'h0}
    };
    foreach (directed[i]) begin
      send(directed[i].op, directed[i].value, directed[i].nib,
           directed[i].has_exp, directed[i].exp_nib);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    random_phase(250);
    wait_idle();

    // zero modulus and extreme register values
    write_reg(bgd_pkg::REG_PRIME_P, 17'd0);
    write_reg(bgd_pkg::REG_COEF_A, 17'h10001);
    random_phase(60);
    wait_idle();
    write_reg(bgd_pkg::REG_PRIME_P, 17'h1FFFF);
    write_reg(bgd_pkg::REG_PRIME_Q, 17'hFFFF);
    write_reg(bgd_pkg::REG_COEF_A, 17'h0FFFF);
    write_reg(bgd_pkg::REG_COEF_B, 17'h10001);
    write_reg(bgd_pkg::REG_EXP_P, 17'hFFFF);
    write_reg(bgd_pkg::REG_EXP_Q, 17'h0);
    random_phase(200);
    wait_idle();
    write_reg(bgd_pkg::REG_PRIME_P, 17'd3);
    write_reg(bgd_pkg::REG_PRIME_Q, 17'd7);
    write_reg(bgd_pkg::REG_COEF_A, 17'h1FFFE);   // -2*3 + 1*7 = 1
    write_reg(bgd_pkg::REG_COEF_B, 17'd1);
    write_reg(bgd_pkg::REG_EXP_P, 17'd1);
    write_reg(bgd_pkg::REG_EXP_Q, 17'd2);
    random_phase(200);
    wait_idle();
    for (int k = 0; k < 2; k++) begin
      write_reg(bgd_pkg::REG_PRIME_P, 17'($urandom));
      write_reg(bgd_pkg::REG_PRIME_Q, 17'($urandom));
      write_reg(bgd_pkg::REG_COEF_A, 17'($urandom));
      write_reg(bgd_pkg::REG_COEF_B, 17'($urandom));
      write_reg(bgd_pkg::REG_EXP_P, 17'($urandom));
      write_reg(bgd_pkg::REG_EXP_Q, 17'($urandom));
      random_phase(170);
      wait_idle();
    end

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end
endmodule

@@ blum_goldwasser_decrypt_core.f @@
hw/rtl/bgd_pkg.sv
hw/rtl/bgd_modmul.sv
hw/rtl/blum_goldwasser_decrypt_core.sv
tb/testbench.sv
